// ===== design/lfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfr_pkg: shared definitions for the LRU frame replacer
// Sizes, request codes and the control bundle that drives the cell row.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int FRAME_BITS  = 8;
  localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_BITS    = 5;
  localparam int OP_BITS     = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_VICTIM = 2'd0,
    OP_PIN    = 2'd1,
    OP_UNPIN  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Broadcast to every cell while a request is being executed.
  typedef struct packed {
    logic                  en;
    logic                  shift_all;  // remove the oldest entry
    logic                  shift_hit;  // remove the matching entry
    logic                  insert;     // append key at the first free cell
    logic [FRAME_BITS-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== design/lfr_cell.sv =====
// ----------------------------------------------------------------------------
// lfr_cell: one position of the recency list
// Holds a frame and its valid bit, compares against the key, and either keeps
// its entry, takes its upper neighbor's entry on a removal, or loads the key.
// ----------------------------------------------------------------------------
module lfr_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lfr_pkg::cell_ctrl_t            ctrl,
  input  logic                           hit_in,
  output logic                           hit_out,
  input  logic                           prev_valid_in,
  output logic                           valid_sh_out,
  input  logic                           nb_valid,
  input  logic [lfr_pkg::FRAME_BITS-1:0] nb_frame,
  output logic                           valid_o,
  output logic [lfr_pkg::FRAME_BITS-1:0] frame_o
);
  import lfr_pkg::*;

  logic                  valid_r;
  logic                  valid_nxt;
  logic [FRAME_BITS-1:0] frame_r;
  logic [FRAME_BITS-1:0] frame_nxt;
  logic                  hit;
  logic                  shift;
  logic                  valid_sh;
  logic [FRAME_BITS-1:0] frame_sh;
  logic                  load;

  assign hit     = valid_r && (frame_r == ctrl.key);
  assign hit_out = hit_in | hit;

  // A removal at this position or below pulls the upper neighbor down.
  assign shift    = ctrl.shift_all | (ctrl.shift_hit & hit_out);
  assign valid_sh = shift ? nb_valid : valid_r;
  assign frame_sh = shift ? nb_frame : frame_r;
  assign valid_sh_out = valid_sh;

  // Valid entries are contiguous, so the first free cell has a valid lower one.
  assign load = ctrl.insert & prev_valid_in & ~valid_sh;

  always_comb begin
    valid_nxt = valid_r;
    frame_nxt = frame_r;
    if (ctrl.en) begin
      valid_nxt = valid_sh | load;
      frame_nxt = load ? ctrl.key : frame_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    frame_r <= frame_nxt;
  end

  assign valid_o = valid_r;
  assign frame_o = frame_r;

endmodule

// ===== design/lru_frame_replacer.sv =====
// ----------------------------------------------------------------------------
// lru_frame_replacer: LRU replacement list for a buffer pool
// A row of cells holds the frames oldest first; one request per pass.
// ----------------------------------------------------------------------------
// A request is registered when start is seen while idle, then executed against the
// cell row with busy high; the result strobe and result fields are registered
// from that execution. Start is ignored while busy is high.
// Reset: synchronous, active low; the list comes up empty, capacity is 16.
// Results cannot be stalled by the receiver.
module lru_frame_replacer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [lfr_pkg::OP_BITS-1:0]    in_op,
  input  logic [lfr_pkg::FRAME_BITS-1:0] in_frame_id,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lfr_pkg::CAP_BITS-1:0]   cfg_data,
  output logic                           out_strobe,
  output logic                           out_victim_valid,
  output logic [lfr_pkg::FRAME_BITS-1:0] out_victim_frame,
  output logic                           out_dropped,
  output logic [lfr_pkg::FRAME_BITS-1:0] out_dropped_frame,
  output logic [lfr_pkg::CNT_BITS-1:0]   out_count
);
  import lfr_pkg::*;

  logic                  pend_r;
  logic [OP_BITS-1:0]    op_r;
  logic [FRAME_BITS-1:0] key_r;
  logic [CAP_BITS-1:0]   cap_r;
  logic [CNT_BITS-1:0]   count_r;
  logic [CNT_BITS-1:0]   count_nxt;

  logic                  strobe_r;
  logic                  vvalid_r;
  logic [FRAME_BITS-1:0] vframe_r;
  logic                  drop_r;
  logic [FRAME_BITS-1:0] dframe_r;

  logic [CNT_BITS-1:0]   eff_cap;
  logic                  found;
  logic                  nonempty;
  logic                  full;
  logic                  vvalid_nxt;
  logic                  drop_nxt;
  cell_ctrl_t            ctrl;

  logic [MAX_ENTRIES:0]   hit_chain;
  logic [MAX_ENTRIES:0]   vsh_chain;
  logic [MAX_ENTRIES-1:0] cell_valid;
  logic [FRAME_BITS-1:0]  cell_frame [MAX_ENTRIES];

  assign busy      = pend_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_BITS'(1);
    end else if (int'(cap_r) > MAX_ENTRIES) begin
      eff_cap = CNT_BITS'(MAX_ENTRIES);
    end else begin
      eff_cap = CNT_BITS'(cap_r);
    end
  end

  assign found    = hit_chain[MAX_ENTRIES];
  assign nonempty = (count_r != '0);
  assign full     = (count_r >= eff_cap) && nonempty;

  always_comb begin
    ctrl       = '0;
    ctrl.en    = pend_r;
    ctrl.key   = key_r;
    vvalid_nxt = 1'b0;
    drop_nxt   = 1'b0;
    count_nxt  = count_r;
    unique case (op_r)
      OP_VICTIM: begin
        vvalid_nxt     = nonempty;
        ctrl.shift_all = nonempty;
        count_nxt      = count_r - CNT_BITS'(nonempty);
      end
      OP_PIN: begin
        ctrl.shift_hit = 1'b1;
        count_nxt      = count_r - CNT_BITS'(found);
      end
      OP_UNPIN: begin
        if (!found) begin
          drop_nxt       = full;
          ctrl.shift_all = full;
          ctrl.insert    = 1'b1;
          count_nxt      = count_r - CNT_BITS'(full) + CNT_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign hit_chain[0] = 1'b0;
  assign vsh_chain[0] = 1'b1;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic                  nb_valid;
    logic [FRAME_BITS-1:0] nb_frame;
    if (i == MAX_ENTRIES - 1) begin : g_top
      assign nb_valid = 1'b0;
      assign nb_frame = '0;
    end else begin : g_mid
      assign nb_valid = cell_valid[i+1];
      assign nb_frame = cell_frame[i+1];
    end
    lfr_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .hit_in       (hit_chain[i]),
      .hit_out      (hit_chain[i+1]),
      .prev_valid_in(vsh_chain[i]),
      .valid_sh_out (vsh_chain[i+1]),
      .nb_valid     (nb_valid),
      .nb_frame     (nb_frame),
      .valid_o      (cell_valid[i]),
      .frame_o      (cell_frame[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
      count_r  <= '0;
      cap_r    <= CAP_BITS'(16);
    end else begin
      strobe_r <= pend_r;
      if (start && !pend_r) begin
        pend_r <= 1'b1;
      end else begin
        pend_r <= 1'b0;
      end
      if (pend_r) begin
        count_r <= count_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
    if (start && !pend_r) begin
      op_r  <= in_op;
      key_r <= in_frame_id;
    end
    if (pend_r) begin
      vvalid_r <= vvalid_nxt;
      vframe_r <= vvalid_nxt ? cell_frame[0] : '0;
      drop_r   <= drop_nxt;
      dframe_r <= drop_nxt ? cell_frame[0] : '0;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_victim_valid  = vvalid_r;
  assign out_victim_frame  = vframe_r;
  assign out_dropped       = drop_r;
  assign out_dropped_frame = dframe_r;
  assign out_count         = count_r;

  // The valid bits of the row always mirror the entry count.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("cell valid bits disagree with entry count");

  // Every executed request yields exactly one result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> strobe_r && !pend_r)
    else $error("executed request did not produce a result");

  // A victim and a drop never come from the same transaction.
  a_excl_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_victim_valid && out_dropped))
    else $error("victim and drop flagged together");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= MAX_ENTRIES)
    else $error("entry count above list depth");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LRU frame replacer
// Drives victim, pin, unpin and idle requests in bursts, with random gaps in most phases,
// changes the capacity register between phases, and checks every result
// against a queue-based model of the recency list.
// ----------------------------------------------------------------------------
module testbench;
  import lfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 100;

  typedef struct packed {
    logic                  victim_valid;
    logic [FRAME_BITS-1:0] victim_frame;
    logic                  dropped;
    logic [FRAME_BITS-1:0] dropped_frame;
    logic [CNT_BITS-1:0]   count;
  } outcome_t;

  // Tracks the replacement list and the results it must produce.
  class lru_list_checker;
    logic [FRAME_BITS-1:0] listed_frames[$];  // oldest first
    logic [CAP_BITS-1:0]   capacity_reg;
    outcome_t              pending_outcomes[$];
    int                    errors;

    function new();
      capacity_reg = 5'd16;
      errors       = 0;
    endfunction

    function void set_capacity(logic [CAP_BITS-1:0] value);
      capacity_reg = value;
    endfunction

    function int pending_count();
      return pending_outcomes.size();
    endfunction

    function int find_frame(logic [FRAME_BITS-1:0] frame);
      for (int i = 0; i < listed_frames.size(); i++) begin
        if (listed_frames[i] == frame) return i;
      end
      return -1;
    endfunction

    function void note_request(op_t op, logic [FRAME_BITS-1:0] frame);
      outcome_t want;
      int       pos;
      int       limit;
      want  = '0;
      limit = capacity_reg;
      // A zero capacity behaves as one; anything above the array size is clamped.
      if (limit < 1) limit = 1;
      if (limit > MAX_ENTRIES) limit = MAX_ENTRIES;
      case (op)
        OP_VICTIM: begin
          if (listed_frames.size() > 0) begin
            want.victim_valid = 1'b1;
            want.victim_frame = listed_frames.pop_front();
          end
        end
        OP_PIN: begin
          pos = find_frame(frame);
          if (pos >= 0) listed_frames.delete(pos);
        end
        OP_UNPIN: begin
          // A frame already listed keeps its old position.
          if (find_frame(frame) < 0) begin
            if (listed_frames.size() >= limit && listed_frames.size() > 0) begin
              want.dropped       = 1'b1;
              want.dropped_frame = listed_frames.pop_front();
            end
            if (listed_frames.size() < MAX_ENTRIES) listed_frames.push_back(frame);
          end
        end
        default: ;
      endcase
      want.count = CNT_BITS'(listed_frames.size());
      pending_outcomes.push_back(want);
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result at %0t with no request outstanding", $time);
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.victim_valid !== want.victim_valid || got.victim_frame !== want.victim_frame ||
          got.dropped !== want.dropped || got.dropped_frame !== want.dropped_frame ||
          got.count !== want.count) begin
        errors++;
        if (errors <= 10)
          $display({"ERROR: mismatch at %0t: expected vv=%0b vf=%02h dr=%0b df=%02h ",
                    "cnt=%0d, got vv=%0b vf=%02h dr=%0b df=%02h cnt=%0d"},
                   $time, want.victim_valid, want.victim_frame, want.dropped,
                   want.dropped_frame, want.count, got.victim_valid, got.victim_frame,
                   got.dropped, got.dropped_frame, got.count);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [OP_BITS-1:0]    in_op = OP_NONE;
  logic [FRAME_BITS-1:0] in_frame_id = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CAP_BITS-1:0]   cfg_data = '0;
  logic                  out_strobe;
  logic                  out_victim_valid;
  logic [FRAME_BITS-1:0] out_victim_frame;
  logic                  out_dropped;
  logic [FRAME_BITS-1:0] out_dropped_frame;
  logic [CNT_BITS-1:0]   out_count;

  lru_list_checker       chk;
  logic [FRAME_BITS-1:0] frame_pool[32];
  int                    pool_size;
  int                    idle_cycles = 0;

  lru_frame_replacer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_frame_id       (in_frame_id),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .out_strobe        (out_strobe),
    .out_victim_valid  (out_victim_valid),
    .out_victim_frame  (out_victim_frame),
    .out_dropped       (out_dropped),
    .out_dropped_frame (out_dropped_frame),
    .out_count         (out_count)
  );

  always #2 clk = ~clk;

  // Every transaction is observed here, so requests are always noted before
  // results of the same edge are checked.
  always @(posedge clk) begin : monitor
    bit active;
    active = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        chk.set_capacity(cfg_data);
        active = 1'b1;
      end
      if (start && !busy) begin
        chk.note_request(op_t'(in_op), in_frame_id);
        active = 1'b1;
      end
      if (out_strobe) begin
        chk.check_outcome({out_victim_valid, out_victim_frame, out_dropped,
                           out_dropped_frame, out_count});
        active = 1'b1;
      end
      if (active) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Leaves start high; the caller lowers it when no request follows.
  task automatic send_request(op_t op, logic [FRAME_BITS-1:0] frame);
    start       <= 1'b1;
    in_op       <= op;
    in_frame_id <= frame;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (chk.pending_count() != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_request(output op_t op, output logic [FRAME_BITS-1:0] frame);
    int r;
    r = $urandom_range(0, 99);
    if (r < 47) op = OP_UNPIN;
    else if (r < 72) op = OP_PIN;
    else if (r < 93) op = OP_VICTIM;
    else op = OP_NONE;
    // Mostly reuse a small set of frames so pins and repeated unpins hit.
    if ($urandom_range(0, 4) != 0) frame = frame_pool[$urandom_range(0, pool_size - 1)];
    else frame = FRAME_BITS'($urandom_range(0, 255));
  endtask

  task automatic run_phase(int n, bit no_gaps);
    int                    sent;
    int                    burst;
    int                    gap;
    op_t                   op;
    logic [FRAME_BITS-1:0] frame;
    sent      = 0;
    pool_size = $urandom_range(4, 28);
    for (int i = 0; i < 32; i++) frame_pool[i] = FRAME_BITS'($urandom_range(0, 255));
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < n; i++) begin
        pick_request(op, frame);
        send_request(op, frame);
        sent++;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (sent < n && gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    logic [CAP_BITS-1:0] phase_caps[11];
    chk         = new();
    phase_caps  = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd0, 5'd17, 5'd3, 5'd8,
                    5'd16, 5'd5, 5'd12};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list, then inserts, a repeated unpin, pins that hit and miss.
    send_request(OP_VICTIM, 8'h00);
    send_request(OP_PIN,    8'h10);
    send_request(OP_NONE,   8'hFF);
    send_request(OP_UNPIN,  8'h00);
    send_request(OP_UNPIN,  8'hFF);
    send_request(OP_UNPIN,  8'hAA);
    send_request(OP_UNPIN,  8'h55);
    send_request(OP_UNPIN,  8'hFF);
    send_request(OP_PIN,    8'hAA);
    send_request(OP_PIN,    8'h77);
    send_request(OP_VICTIM, 8'h12);
    send_request(OP_NONE,   8'h00);
    start <= 1'b0;

    // Zero capacity acts as one while two frames are still listed.
    write_capacity(5'd0);
    send_request(OP_UNPIN,  8'h33);
    send_request(OP_UNPIN,  8'h33);
    send_request(OP_VICTIM, 8'h00);
    send_request(OP_UNPIN,  8'h01);
    start <= 1'b0;

    write_capacity(5'd31);
    send_request(OP_PIN,    8'h01);
    send_request(OP_VICTIM, 8'hFF);
    start <= 1'b0;

    write_capacity(5'd2);
    send_request(OP_UNPIN,  8'h80);
    send_request(OP_UNPIN,  8'h7F);
    send_request(OP_UNPIN,  8'h80);
    send_request(OP_UNPIN,  8'h40);
    start <= 1'b0;

    foreach (phase_caps[p]) begin
      if (p == 8) write_capacity(CAP_BITS'($urandom_range(0, 31)));
      else write_capacity(phase_caps[p]);
      run_phase(PHASE_ITEMS, (p % 4) == 1);
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (chk.errors == 0 && chk.pending_count() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
